// ----- rtl/pobn_pkg.sv -----
// Package: widths, state and command types and helpers for the polyline offset core
`default_nettype none
package pobn_pkg;
   localparam int CW     = 32;        // coordinate width
   localparam int FB     = 16;        // fraction bits
   localparam int NW     = FB + 2;    // signed unit normal width
   localparam int SW     = NW + 1;    // sum of two normals
   localparam int DW     = CW + 1;    // coordinate difference
   localparam int QW     = FB + 1;    // quotient width
   localparam int XW     = 2 * CW;    // square root working width
   localparam int PW     = CW + QW;   // offset product width
   localparam int CNT_W  = 5;
   localparam int SQRT_STEPS = CW;

   typedef enum logic [4:0] {
      ST_IDLE, ST_STORE, ST_LONE, ST_LOAD, ST_NORM, ST_SQA, ST_SQB, ST_SQRT,
      ST_DIVA_INIT, ST_DIVA, ST_DIVB_INIT, ST_DIVB, ST_FIN,
      ST_MULX, ST_ADDX, ST_MULY, ST_ADDY
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_STORE, OP_LONE, OP_LOAD, OP_NORM, OP_SQA, OP_SQB,
      OP_SQRT, OP_DIV_INIT_A, OP_DIV_INIT_B, OP_DIV_STEP, OP_FIN,
      OP_MULX, OP_ADDX, OP_MULY, OP_ADDY
   } op_type;

   typedef enum logic [1:0] {
      EMIT_PREV_SEG, EMIT_PREV_SUM, EMIT_CUR_SEG
   } emit_type;

   typedef struct packed {
      op_type   op;
      logic     sum_pass;
      emit_type esel;
      logic     commit;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic norm_done;
      logic out_free;
   } status_type;

   // point +/- rounded (prod / 2^FB), saturated
   function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] pt,
                                                     input logic [PW-1:0] prod,
                                                     input logic neg);
      logic [PW-1:0]        rnd;
      logic [PW-FB-1:0]     m;
      logic signed [CW+2:0] res;
      rnd = prod + PW'(1 << (FB - 1));
      m   = rnd[PW-1:FB];
      if (neg) res = {{3{pt[CW-1]}}, pt} - {{(CW+3-(PW-FB)){1'b0}}, m};
      else     res = {{3{pt[CW-1]}}, pt} + {{(CW+3-(PW-FB)){1'b0}}, m};
      if (res[CW+2:CW-1] == 4'b0000 || res[CW+2:CW-1] == 4'b1111)
         return res[CW-1:0];
      else if (res[CW+2])
         return {1'b1, {(CW-1){1'b0}}};
      else
         return {1'b0, {(CW-1){1'b1}}};
   endfunction
endpackage
`default_nettype wire

// ----- rtl/polyline_offset_by_normals_core.sv -----
// Top level: polyline offset along averaged vertex normals
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  point_x, point_y, final_point
//  rsp      out        rsp_valid/rsp_ready  out_x, out_y, degenerate, end_of_line
//  csr      in         csr_wr_en            csr_wr_data (offset_amount)
//
// Each normalization runs in the shared root/divide unit; a second point costs one
// normalization, later points two.
// Synchronous reset clears control and offset_amount; no clearing pass.
// A result stalled on rsp_ready holds the datapath only when the next result is due.
`default_nettype none
module polyline_offset_by_normals_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [pobn_pkg::CW-1:0] req_point_x,
   input  wire logic signed [pobn_pkg::CW-1:0] req_point_y,
   input  wire logic                         req_final_point,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [pobn_pkg::CW-1:0]    rsp_out_x,
   output logic signed [pobn_pkg::CW-1:0]    rsp_out_y,
   output logic                              rsp_degenerate,
   output logic                              rsp_end_of_line,
   input  wire logic                         csr_wr_en,
   input  wire logic signed [pobn_pkg::CW-1:0] csr_wr_data
);
   import pobn_pkg::*;

   cmd_type    cmd;
   status_type status;

   pobn_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_final_point (req_final_point),
      .status          (status),
      .cmd             (cmd)
   );

   pobn_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_end_of_line (rsp_end_of_line)
   );
endmodule
`default_nettype wire

// ----- rtl/pobn_dpath.sv -----
// Datapath: point store, normalizer, square root, divider, offset multiplier, output register
`default_nettype none
module pobn_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pobn_pkg::cmd_type            cmd,
   output pobn_pkg::status_type              status,
   input  wire logic signed [pobn_pkg::CW-1:0] req_point_x,
   input  wire logic signed [pobn_pkg::CW-1:0] req_point_y,
   input  wire logic                         csr_wr_en,
   input  wire logic signed [pobn_pkg::CW-1:0] csr_wr_data,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic signed [pobn_pkg::CW-1:0]    rsp_out_x,
   output logic signed [pobn_pkg::CW-1:0]    rsp_out_y,
   output logic                              rsp_degenerate,
   output logic                              rsp_end_of_line
);
   import pobn_pkg::*;

   logic signed [CW-1:0] offset_ff, cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic signed [NW-1:0] pnx_ff, pny_ff, seg_nx_ff, seg_ny_ff, sum_nx_ff, sum_ny_ff;
   logic                 seg_deg_ff, sum_deg_ff;
   logic [CW-1:0]        ua_ff, ub_ff, rem_ff;
   logic                 neg_a_ff, neg_b_ff, zero_ff;
   logic [XW-1:0]        sqa_ff, x_ff, r_ff, bit_ff;
   logic [QW-1:0]        num_ff, q_ff, qa_ff;
   logic [PW-1:0]        prod_ff;
   logic                 neg_ff, rsp_valid_ff;
   logic signed [CW-1:0] pt_ff, resx_ff;

   logic signed [DW-1:0] dx, dy, a_sel, b_sel, mag_a, mag_b;
   logic signed [SW-1:0] sa, sb;
   logic [CW-1:0]        mx, len;
   logic [XW-1:0]        rb;
   logic [CW:0]          rem2;
   logic                 ge;
   logic [CW+FB-1:0]     nume;
   logic [CW-1:0]        div_src, amt_mag;
   logic signed [NW-1:0] nxv, nyv, nyp, enx, eny, en;
   logic signed [CW-1:0] epx, epy, ep;
   logic                 edeg;
   logic [QW-1:0]        un;

   always_comb begin
      dx = {cur_x_ff[CW-1], cur_x_ff} - {prev_x_ff[CW-1], prev_x_ff};
      dy = {cur_y_ff[CW-1], cur_y_ff} - {prev_y_ff[CW-1], prev_y_ff};
      sa = {pnx_ff[NW-1], pnx_ff} + {seg_nx_ff[NW-1], seg_nx_ff};
      sb = {pny_ff[NW-1], pny_ff} + {seg_ny_ff[NW-1], seg_ny_ff};
      if (cmd.sum_pass) begin
         a_sel = {{(DW-SW){sa[SW-1]}}, sa};
         b_sel = {{(DW-SW){sb[SW-1]}}, sb};
      end else begin
         a_sel = dy;
         b_sel = dx;
      end
      mag_a = a_sel[DW-1] ? -a_sel : a_sel;
      mag_b = b_sel[DW-1] ? -b_sel : b_sel;
      mx    = (ua_ff > ub_ff) ? ua_ff : ub_ff;
      rb    = r_ff + bit_ff;
      len   = r_ff[CW-1:0];
      rem2  = {rem_ff, num_ff[QW-1]};
      ge    = rem2 >= {1'b0, len};
      div_src = (cmd.op == OP_DIV_INIT_A) ? ua_ff : ub_ff;
      nume  = {div_src, {FB{1'b0}}} + {{(FB+1){1'b0}}, len[CW-1:1]};
      nxv   = zero_ff ? '0 : (neg_a_ff ? -$signed({1'b0, qa_ff}) : $signed({1'b0, qa_ff}));
      nyp   = zero_ff ? '0 : (neg_b_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff}));
      nyv   = cmd.sum_pass ? nyp : -nyp;
      unique case (cmd.esel)
         EMIT_PREV_SUM: begin
            epx = prev_x_ff; epy = prev_y_ff; enx = sum_nx_ff; eny = sum_ny_ff;
            edeg = sum_deg_ff;
         end
         EMIT_CUR_SEG: begin
            epx = cur_x_ff; epy = cur_y_ff; enx = seg_nx_ff; eny = seg_ny_ff;
            edeg = seg_deg_ff;
         end
         default: begin
            epx = prev_x_ff; epy = prev_y_ff; enx = seg_nx_ff; eny = seg_ny_ff;
            edeg = seg_deg_ff;
         end
      endcase
      en      = (cmd.op == OP_MULY) ? eny : enx;
      ep      = (cmd.op == OP_MULY) ? epy : epx;
      un      = en[NW-1] ? QW'(-en) : QW'(en);
      amt_mag = offset_ff[CW-1] ? -offset_ff : offset_ff;
   end

   assign status.zero      = zero_ff;
   assign status.norm_done = (mx[CW-1:CW-2] == 2'b01);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) offset_ff <= csr_wr_data;
         if (cmd.op == OP_ADDY || cmd.op == OP_LONE) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op) inside
         OP_CAPTURE: begin
            cur_x_ff <= req_point_x;
            cur_y_ff <= req_point_y;
         end
         OP_STORE: begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         OP_LONE: begin
            rsp_out_x       <= cur_x_ff;
            rsp_out_y       <= cur_y_ff;
            rsp_degenerate  <= 1'b0;
            rsp_end_of_line <= 1'b1;
         end
         OP_LOAD: begin
            ua_ff    <= mag_a[CW-1:0];
            ub_ff    <= mag_b[CW-1:0];
            neg_a_ff <= a_sel[DW-1];
            neg_b_ff <= b_sel[DW-1];
            zero_ff  <= (a_sel == '0) && (b_sel == '0);
         end
         OP_NORM: begin
            if (mx[CW-1]) begin
               ua_ff <= ua_ff >> 1;
               ub_ff <= ub_ff >> 1;
            end else if (!mx[CW-2]) begin
               ua_ff <= ua_ff << 1;
               ub_ff <= ub_ff << 1;
            end
         end
         OP_SQA: begin
            sqa_ff <= XW'(ua_ff[CW-2:0] * ua_ff[CW-2:0]);
         end
         OP_SQB: begin
            x_ff   <= sqa_ff + XW'(ub_ff[CW-2:0] * ub_ff[CW-2:0]);
            r_ff   <= '0;
            bit_ff <= XW'(1) << (XW - 2);
         end
         OP_SQRT: begin
            if (x_ff >= rb) begin
               x_ff <= x_ff - rb;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_DIV_INIT_A, OP_DIV_INIT_B: begin
            if (cmd.op == OP_DIV_INIT_B) qa_ff <= q_ff;
            rem_ff <= {1'b0, nume[CW+FB-1:QW]};
            num_ff <= nume[QW-1:0];
            q_ff   <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff <= ge ? CW'(rem2 - {1'b0, len}) : rem2[CW-1:0];
            q_ff   <= {q_ff[QW-2:0], ge};
            num_ff <= num_ff << 1;
         end
         OP_FIN: begin
            if (cmd.sum_pass) begin
               sum_nx_ff  <= nxv;
               sum_ny_ff  <= nyv;
               sum_deg_ff <= zero_ff;
            end else begin
               seg_nx_ff  <= nxv;
               seg_ny_ff  <= nyv;
               seg_deg_ff <= zero_ff;
            end
         end
         OP_MULX, OP_MULY: begin
            prod_ff <= amt_mag * un;
            neg_ff  <= offset_ff[CW-1] ^ en[NW-1];
            pt_ff   <= ep;
         end
         OP_ADDX: begin
            resx_ff <= sat_add(pt_ff, prod_ff, neg_ff);
         end
         OP_ADDY: begin
            rsp_out_x       <= resx_ff;
            rsp_out_y       <= sat_add(pt_ff, prod_ff, neg_ff);
            rsp_degenerate  <= edeg;
            rsp_end_of_line <= (cmd.esel == EMIT_CUR_SEG);
            if (cmd.commit) begin
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
               pnx_ff    <= seg_nx_ff;
               pny_ff    <= seg_ny_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ----- rtl/pobn_ctrl.sv -----
// Controller: sequences normal computation, averaging and result emission per point
`default_nettype none
module pobn_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_final_point,
   input  wire pobn_pkg::status_type status,
   output pobn_pkg::cmd_type         cmd
);
   import pobn_pkg::*;

   state_type        state_ff, state_in;
   logic [1:0]       ps_ff, ps_in;
   logic             fin_ff, fin_in, pass_ff, pass_in;
   emit_type         esel_ff, esel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ps_ff    <= '0;
         fin_ff   <= 1'b0;
         pass_ff  <= 1'b0;
         esel_ff  <= EMIT_PREV_SEG;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ps_ff    <= ps_in;
         fin_ff   <= fin_in;
         pass_ff  <= pass_in;
         esel_ff  <= esel_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ps_in    = ps_ff;
      fin_in   = fin_ff;
      pass_in  = pass_ff;
      esel_in  = esel_ff;
      cnt_in   = cnt_ff;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.sum_pass = pass_ff;
      cmd.esel     = esel_ff;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_CAPTURE;
               fin_in = req_final_point;
               if (ps_ff == 2'd0) state_in = req_final_point ? ST_LONE : ST_STORE;
               else begin
                  pass_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_STORE: begin
            cmd.op   = OP_STORE;
            ps_in    = 2'd1;
            state_in = ST_IDLE;
         end
         ST_LONE: begin
            if (status.out_free) begin
               cmd.op   = OP_LONE;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.zero)           state_in = ST_FIN;
            else if (status.norm_done) state_in = ST_SQA;
            else                       cmd.op   = OP_NORM;
         end
         ST_SQA: begin
            cmd.op   = OP_SQA;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            cmd.op   = OP_SQB;
            cnt_in   = CNT_W'(SQRT_STEPS - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_DIVA_INIT;
         end
         ST_DIVA_INIT: begin
            cmd.op   = OP_DIV_INIT_A;
            cnt_in   = CNT_W'(QW - 1);
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_DIVB_INIT;
         end
         ST_DIVB_INIT: begin
            cmd.op   = OP_DIV_INIT_B;
            cnt_in   = CNT_W'(QW - 1);
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op = OP_FIN;
            if (pass_ff) begin
               esel_in  = EMIT_PREV_SUM;
               state_in = ST_MULX;
            end else if (ps_ff == 2'd1) begin
               esel_in  = EMIT_PREV_SEG;
               state_in = ST_MULX;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_MULX: begin
            cmd.op   = OP_MULX;
            state_in = ST_ADDX;
         end
         ST_ADDX: begin
            cmd.op   = OP_ADDX;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            cmd.op   = OP_MULY;
            state_in = ST_ADDY;
         end
         ST_ADDY: begin
            if (status.out_free) begin
               cmd.op = OP_ADDY;
               if (esel_ff == EMIT_CUR_SEG) begin
                  ps_in    = 2'd0;
                  state_in = ST_IDLE;
               end else if (fin_ff) begin
                  esel_in  = EMIT_CUR_SEG;
                  state_in = ST_MULX;
               end else begin
                  cmd.commit = 1'b1;
                  ps_in      = 2'd2;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/pobn_checker.sv -----
// Checker: port-level properties of the polyline offset core, bound to the top level
`default_nettype none
module pobn_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [pobn_pkg::CW-1:0] rsp_out_x,
   input wire logic signed [pobn_pkg::CW-1:0] rsp_out_y,
   input wire logic                         rsp_degenerate,
   input wire logic                         rsp_end_of_line
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
      && $stable(rsp_degenerate) && $stable(rsp_end_of_line))
      else $error("stalled result transaction changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous transaction in progress");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("outputs not idle after reset");

   a_no_result_while_ready_twice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && req_ready && !req_valid |=> !rsp_valid)
      else $error("result appeared while idle");
endmodule

bind polyline_offset_by_normals_core pobn_checker u_pobn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_degenerate  (rsp_degenerate),
   .rsp_end_of_line (rsp_end_of_line)
);
`default_nettype wire
